// ===== hw/rtl/bcdc_pkg.sv =====
// Package for the battery charge duty controller: widths, phase and
// measurement codes, register indexes, state and item types, helper functions.
// No dependencies.
package bcdc_pkg;

  localparam int unsigned VOLT_W  = 16;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned TWICE_W = VOLT_W + 1;
  localparam int unsigned BOUND_W = DUTY_W + 2;
  localparam int unsigned TOL_W   = 10;
  localparam int unsigned LIM_W   = 11;
  localparam int unsigned STEPS_W = 4;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CIDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_TOLERANCE = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_TEMP_LIM  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_TEST_DUTY = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_MAX_DUTY  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_STEPS     = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_INIT_UNLOADED = 3'd1,
    PH_INIT_TEST     = 3'd2,
    PH_SEARCH        = 3'd3,
    PH_CHG_LOADED    = 3'd4,
    PH_CHG_UNLOADED  = 3'd5,
    PH_CHG_TEST      = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_UNLOADED = 2'd0,
    KIND_LOADED   = 2'd1,
    KIND_NONE     = 2'd2
  } kind_e;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_REPORT = 1'b1
  } op_e;

  typedef struct packed {
    logic [TOL_W-1:0]   tolerance_mv;
    logic [LIM_W-1:0]   temp_limit;
    logic [DUTY_W-1:0]  test_duty;
    logic [DUTY_W-1:0]  max_duty;
    logic [STEPS_W-1:0] search_steps;
  } cfg_t;

  typedef struct packed {
    phase_e                     phase;
    logic [VOLT_W-1:0]          unloaded_mv;
    logic [TWICE_W-1:0]         target_twice;
    logic signed [BOUND_W-1:0]  search_low;
    logic signed [BOUND_W-1:0]  search_high;
    logic [DUTY_W-1:0]          duty_now;
    logic [STEPS_W-1:0]         step_count;
    logic                       converged;
    logic [VOLT_W-1:0]          loaded_mv;
    logic signed [TEMP_W-1:0]   loaded_temp;
  } state_t;

  typedef struct packed {
    logic                     op;
    logic [VOLT_W-1:0]        voltage_mv;
    logic signed [TEMP_W-1:0] temp_diff;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] request_duty;
    logic [1:0]        request_kind;
    logic [DUTY_W-1:0] charge_duty;
    logic              converged;
    logic [2:0]        phase_now;
    logic              done_res;
  } out_item_t;

  function automatic logic [TWICE_W-1:0] abs_diff(input logic [TWICE_W-1:0] a,
                                                  input logic [TWICE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Midpoint of the search bounds; a negative sum gives zero.
  function automatic logic [DUTY_W-1:0] midpoint(input logic signed [BOUND_W-1:0] lo,
                                                 input logic signed [BOUND_W-1:0] hi);
    logic signed [BOUND_W:0] s;
    s = {lo[BOUND_W-1], lo} + {hi[BOUND_W-1], hi};
    if (s < 0) begin
      return '0;
    end
    return s[DUTY_W:1];
  endfunction

endpackage

// ===== hw/rtl/bcdc_in_if.sv =====
// Input channel of the charge duty controller: valid/ready and one report item.
// Depends on bcdc_pkg for field widths.
interface bcdc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [bcdc_pkg::VOLT_W-1:0]       voltage_mv;
  logic signed [bcdc_pkg::TEMP_W-1:0] temp_diff;

  modport source (output valid, op, voltage_mv, temp_diff, input ready);
  modport sink   (input valid, op, voltage_mv, temp_diff, output ready);
endinterface

// ===== hw/rtl/bcdc_out_if.sv =====
// Result channel of the charge duty controller: valid/ready and one result item.
// Depends on bcdc_pkg for field widths.
interface bcdc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bcdc_pkg::DUTY_W-1:0] request_duty;
  logic [1:0]                  request_kind;
  logic [bcdc_pkg::DUTY_W-1:0] charge_duty;
  logic                        converged;
  logic [2:0]                  phase_now;
  logic                        done_res;

  modport source (output valid, request_duty, request_kind, charge_duty, converged,
                  phase_now, done_res, input ready);
  modport sink   (input valid, request_duty, request_kind, charge_duty, converged,
                  phase_now, done_res, output ready);
endinterface

// ===== hw/rtl/battery_charge_duty_controller.sv =====
// Top level of the battery charge duty controller.
// Depends on bcdc_pkg, bcdc_in_if, bcdc_out_if and bcdc_step.

// The controller takes one measurement report item per clock cycle while its
// results are taken, and gives one result item for each, in order. The item is
// first captured in an input register, then one pass of compare and add logic
// updates the charge state and loads the result register, which presents the
// result; a stall on the result side can hold the item in the input register in
// between. Because the state is written at the same edge at which the result is
// loaded, the next item in the input register always sees the up-to-date state,
// so items may follow each other in every cycle while nothing stalls. The result
// register lets a new item be accepted while a finished result still waits to
// be taken; a stall on the result side backs up into the input register and
// then into the input ready. An item with op 0 starts or restarts the charge
// sequence in any phase. The five configuration registers are written through
// a simple write port and take effect for the next item; they should be
// written only while no item is in flight.
module battery_charge_duty_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcdc_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [bcdc_pkg::CFG_W-1:0]    cfg_data_i,
  bcdc_in_if.sink                       in_if,
  bcdc_out_if.source                    out_if
);

  bcdc_pkg::cfg_t      cfg_q;
  bcdc_pkg::state_t    st_q;
  bcdc_pkg::state_t    st_d;
  bcdc_pkg::in_item_t  in_q;
  bcdc_pkg::out_item_t res_q;
  bcdc_pkg::out_item_t res_d;
  logic                in_vld_q;
  logic                out_vld_q;
  logic                in_fire;
  logic                advance;

  // The input register moves on whenever the result register is free or
  // is being emptied in this cycle.
  assign advance      = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready  = !in_vld_q || advance;
  assign in_fire      = in_if.valid && in_if.ready;

  // Configuration registers; writes to indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance_mv <= bcdc_pkg::TOL_W'(50);
      cfg_q.temp_limit   <= bcdc_pkg::LIM_W'(80);
      cfg_q.test_duty    <= bcdc_pkg::DUTY_W'(128);
      cfg_q.max_duty     <= bcdc_pkg::DUTY_W'(255);
      cfg_q.search_steps <= bcdc_pkg::STEPS_W'(10);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcdc_pkg::CFG_TOLERANCE: cfg_q.tolerance_mv <= cfg_data_i[bcdc_pkg::TOL_W-1:0];
        bcdc_pkg::CFG_TEMP_LIM:  cfg_q.temp_limit   <= cfg_data_i[bcdc_pkg::LIM_W-1:0];
        bcdc_pkg::CFG_TEST_DUTY: cfg_q.test_duty    <= cfg_data_i[bcdc_pkg::DUTY_W-1:0];
        bcdc_pkg::CFG_MAX_DUTY:  cfg_q.max_duty     <= cfg_data_i[bcdc_pkg::DUTY_W-1:0];
        bcdc_pkg::CFG_STEPS:     cfg_q.search_steps <= cfg_data_i[bcdc_pkg::STEPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: valid bit under reset, payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.op         <= in_if.op;
      in_q.voltage_mv <= in_if.voltage_mv;
      in_q.temp_diff  <= in_if.temp_diff;
    end
  end

  bcdc_step u_step (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .item_i (in_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // Charge state is updated when its item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase        <= bcdc_pkg::PH_IDLE;
      st_q.unloaded_mv  <= '0;
      st_q.target_twice <= '0;
      st_q.search_low   <= '0;
      st_q.search_high  <= '0;
      st_q.duty_now     <= '0;
      st_q.step_count   <= '0;
      st_q.converged    <= 1'b0;
      st_q.loaded_mv    <= '0;
      st_q.loaded_temp  <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_if.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid        = out_vld_q;
  assign out_if.request_duty = res_q.request_duty;
  assign out_if.request_kind = res_q.request_kind;
  assign out_if.charge_duty  = res_q.charge_duty;
  assign out_if.converged    = res_q.converged;
  assign out_if.phase_now    = res_q.phase_now;
  assign out_if.done_res     = res_q.done_res;

endmodule

// ===== hw/rtl/bcdc_step.sv =====
// Next-state and result logic of the charge duty controller for one item.
// Depends on bcdc_pkg.
module bcdc_step (
  input  bcdc_pkg::state_t    st_i,
  input  bcdc_pkg::cfg_t      cfg_i,
  input  bcdc_pkg::in_item_t  item_i,
  output bcdc_pkg::state_t    st_o,
  output bcdc_pkg::out_item_t res_o
);

  logic [bcdc_pkg::TWICE_W-1:0]        twice_v;
  logic [bcdc_pkg::TWICE_W-1:0]        twice_l;
  logic [bcdc_pkg::TWICE_W-1:0]        lim;
  logic [bcdc_pkg::TWICE_W-1:0]        tgt_new;
  logic [bcdc_pkg::TWICE_W-1:0]        srch_dev;
  logic [bcdc_pkg::TWICE_W-1:0]        chg_dev;
  logic [bcdc_pkg::STEPS_W-1:0]        step_inc;
  logic signed [bcdc_pkg::BOUND_W-1:0] low_n;
  logic signed [bcdc_pkg::BOUND_W-1:0] high_n;
  logic                                hit;
  logic signed [bcdc_pkg::TEMP_W:0]    temp_ext;
  logic signed [bcdc_pkg::TEMP_W:0]    lim_ext;
  logic                                temp_stop;
  bcdc_pkg::state_t                    st_d;
  bcdc_pkg::kind_e                     kind;
  logic [bcdc_pkg::DUTY_W-1:0]         rduty;

  assign twice_v  = {item_i.voltage_mv, 1'b0};
  assign twice_l  = {st_i.loaded_mv, 1'b0};
  assign lim      = bcdc_pkg::TWICE_W'({cfg_i.tolerance_mv, 1'b0});
  assign tgt_new  = bcdc_pkg::TWICE_W'(st_i.unloaded_mv) +
                    bcdc_pkg::TWICE_W'(item_i.voltage_mv);
  assign srch_dev = bcdc_pkg::abs_diff(twice_v, st_i.target_twice);
  assign chg_dev  = bcdc_pkg::abs_diff(twice_l, tgt_new);
  assign step_inc = st_i.step_count + 1'b1;
  assign hit      = srch_dev < lim;
  assign temp_ext = {st_i.loaded_temp[bcdc_pkg::TEMP_W-1], st_i.loaded_temp};
  assign lim_ext  = $signed({{(bcdc_pkg::TEMP_W + 1 - bcdc_pkg::LIM_W){1'b0}},
                             cfg_i.temp_limit});
  assign temp_stop = temp_ext > lim_ext;

  // Search bounds after a measurement that missed the window.
  always_comb begin
    low_n  = st_i.search_low;
    high_n = st_i.search_high;
    if (!hit) begin
      if (twice_v > st_i.target_twice) begin
        low_n = $signed({2'b00, st_i.duty_now} + bcdc_pkg::BOUND_W'(1));
      end else begin
        high_n = $signed({2'b00, st_i.duty_now} - bcdc_pkg::BOUND_W'(1));
      end
    end
  end

  // Next state.
  always_comb begin
    st_d = st_i;
    if (item_i.op == bcdc_pkg::OP_START) begin
      st_d.phase       = bcdc_pkg::PH_INIT_UNLOADED;
      st_d.search_low  = '0;
      st_d.search_high = '0;
      st_d.step_count  = '0;
      st_d.converged   = 1'b0;
      st_d.duty_now    = cfg_i.test_duty;
    end else begin
      unique case (st_i.phase)
        bcdc_pkg::PH_INIT_UNLOADED: begin
          st_d.unloaded_mv = item_i.voltage_mv;
          st_d.phase       = bcdc_pkg::PH_INIT_TEST;
        end
        bcdc_pkg::PH_INIT_TEST: begin
          st_d.target_twice = tgt_new;
          st_d.search_low   = '0;
          st_d.search_high  = $signed({2'b00, cfg_i.max_duty});
          st_d.step_count   = '0;
          st_d.converged    = 1'b0;
          if (cfg_i.search_steps == '0) begin
            st_d.duty_now = cfg_i.test_duty;
            st_d.phase    = bcdc_pkg::PH_CHG_LOADED;
          end else begin
            st_d.duty_now = cfg_i.max_duty >> 1;
            st_d.phase    = bcdc_pkg::PH_SEARCH;
          end
        end
        bcdc_pkg::PH_SEARCH: begin
          st_d.search_low  = low_n;
          st_d.search_high = high_n;
          st_d.step_count  = step_inc;
          if (hit) begin
            st_d.converged = 1'b1;
          end
          if (hit || st_i.converged || step_inc >= cfg_i.search_steps) begin
            st_d.phase = bcdc_pkg::PH_CHG_LOADED;
          end else begin
            st_d.duty_now = bcdc_pkg::midpoint(low_n, high_n);
          end
        end
        bcdc_pkg::PH_CHG_LOADED: begin
          st_d.loaded_mv   = item_i.voltage_mv;
          st_d.loaded_temp = item_i.temp_diff;
          st_d.phase       = bcdc_pkg::PH_CHG_UNLOADED;
        end
        bcdc_pkg::PH_CHG_UNLOADED: begin
          st_d.unloaded_mv = item_i.voltage_mv;
          st_d.phase       = bcdc_pkg::PH_CHG_TEST;
        end
        bcdc_pkg::PH_CHG_TEST: begin
          st_d.target_twice = tgt_new;
          if (chg_dev > lim) begin
            if (twice_l > tgt_new && st_i.duty_now < cfg_i.max_duty) begin
              st_d.duty_now = st_i.duty_now + 1'b1;
            end else if (twice_l < tgt_new && st_i.duty_now != '0) begin
              st_d.duty_now = st_i.duty_now - 1'b1;
            end
          end
          st_d.phase = temp_stop ? bcdc_pkg::PH_IDLE : bcdc_pkg::PH_CHG_LOADED;
        end
        default: begin
          st_d.phase = bcdc_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Result fields.
  always_comb begin
    rduty = '0;
    kind  = bcdc_pkg::KIND_NONE;
    if (item_i.op == bcdc_pkg::OP_START) begin
      kind = bcdc_pkg::KIND_UNLOADED;
    end else begin
      unique case (st_i.phase)
        bcdc_pkg::PH_INIT_UNLOADED,
        bcdc_pkg::PH_CHG_UNLOADED: begin
          rduty = cfg_i.test_duty;
          kind  = bcdc_pkg::KIND_LOADED;
        end
        bcdc_pkg::PH_INIT_TEST,
        bcdc_pkg::PH_SEARCH: begin
          rduty = st_d.duty_now;
          kind  = bcdc_pkg::KIND_LOADED;
        end
        bcdc_pkg::PH_CHG_LOADED: begin
          kind = bcdc_pkg::KIND_UNLOADED;
        end
        bcdc_pkg::PH_CHG_TEST: begin
          if (!temp_stop) begin
            rduty = st_d.duty_now;
            kind  = bcdc_pkg::KIND_LOADED;
          end
        end
        default: begin
          kind = bcdc_pkg::KIND_NONE;
        end
      endcase
    end
  end

  assign st_o               = st_d;
  assign res_o.request_duty = rduty;
  assign res_o.request_kind = kind;
  assign res_o.charge_duty  = st_d.duty_now;
  assign res_o.converged    = st_d.converged;
  assign res_o.phase_now    = st_d.phase;
  assign res_o.done_res     = (item_i.op == bcdc_pkg::OP_REPORT) &&
                              (st_i.phase == bcdc_pkg::PH_CHG_TEST) && temp_stop;

endmodule
